// ===== rtl/tccs_pkg.sv =====
package tccs_pkg;

    typedef logic [31:0] t_angle;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_STEPS       = 24;

    localparam int LIMIT_W      = 15;
    localparam int HEAD_W       = 15;
    localparam int SECT_W       = 3;
    localparam int Q_BITS       = 16;
    localparam int SINE_SHIFT   = 23;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd21063;
    localparam int HEAD_FULL = 23040;
    localparam int DEG25     = 1600;
    localparam int DEG340    = 21760;
    localparam int DEG45     = 2880;

    localparam t_angle ATAN_TAB [ATAN_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

// ===== rtl/tccs_delay.sv =====
module tccs_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[DEPTH-1];
endmodule

// ===== rtl/tccs_isqrt.sv =====
module tccs_isqrt #(
    parameter int N = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*N-1:0] i_n,
    output logic [N-1:0]   o_root
);
    localparam int RW = 2*N + 2;

    logic [RW-1:0] r_rem  [N];
    logic [N-1:0]  r_root [N];

    // one result bit per stage, most significant first
    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        logic [RW-1:0] rem_in;
        logic [N-1:0]  root_in;
        logic [RW-1:0] trial;

        if (j == 0) begin : g_first
            assign rem_in  = RW'(i_n);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[j]  <= rem_in - trial;
                    r_root[j] <= root_in | (N'(1) << K);
                end else begin
                    r_rem[j]  <= rem_in;
                    r_root[j] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[N-1];
endmodule

// ===== rtl/tccs_div.sv =====
module tccs_div #(
    parameter int NW = 16,
    parameter int DW = 25
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [NW-1:0]           i_num,
    input  logic [DW-1:0]           i_den,
    output logic [tccs_pkg::Q_BITS-1:0] o_quo
);
    import tccs_pkg::*;

    localparam int RW = NW + DW + Q_BITS + SINE_SHIFT;

    logic [RW-1:0]     r_rem [Q_BITS];
    logic [DW-1:0]     r_den [Q_BITS];
    logic [Q_BITS-1:0] r_quo [Q_BITS];

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
        localparam int K = Q_BITS - 1 - j;
        logic [RW-1:0]     rem_in;
        logic [DW-1:0]     den_in;
        logic [Q_BITS-1:0] quo_in;
        logic [RW-1:0]     sub;

        if (j == 0) begin : g_first
            assign rem_in = RW'(i_num) << SINE_SHIFT;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign sub = RW'(den_in) << K;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= den_in;
                if (rem_in >= sub) begin
                    r_rem[j] <= rem_in - sub;
                    r_quo[j] <= quo_in | (Q_BITS'(1) << K);
                end else begin
                    r_rem[j] <= rem_in;
                    r_quo[j] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[Q_BITS-1];
endmodule

// ===== rtl/tccs_cordic.sv =====
module tccs_cordic #(
    parameter int TW    = 50,
    parameter int STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [TW-1:0]   i_x,
    input  logic signed [TW-1:0]   i_y,
    output tccs_pkg::t_angle       o_ang,
    output logic                   o_zero
);
    import tccs_pkg::*;

    localparam int XW = TW + 2;

    logic signed [XW-1:0] r_x [STEPS+1];
    logic signed [XW-1:0] r_y [STEPS+1];
    t_angle               r_a [STEPS+1];
    logic                 r_z [STEPS+1];

    // fold the left half plane onto the right, start at 180 degrees
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[TW-1]) begin
                r_x[0] <= -XW'(i_x);
                r_y[0] <= -XW'(i_y);
                r_a[0] <= 32'h8000_0000;
            end else begin
                r_x[0] <= XW'(i_x);
                r_y[0] <= XW'(i_y);
                r_a[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic                 y_pos;

        assign dx    = r_y[i] >>> i;
        assign dy    = r_x[i] >>> i;
        assign y_pos = !r_y[i][XW-1] && (r_y[i] != '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i+1] <= r_z[i];
                if (y_pos) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_a[i+1] <= r_a[i] + ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_a[i+1] <= r_a[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign o_ang  = r_a[STEPS];
    assign o_zero = r_z[STEPS];
endmodule

// ===== rtl/tilt_compensated_compass_sector_top.sv =====
// Tilt compensated compass heading with sector and level flag.
//
// Input stream: one word per sample carries six signed axes. Output stream:
// one word per sample with heading (1/64 degree), sector and level.
// Config channel: writes the Q15 tilt limit; always ready, write it only
// while no sample is in flight.
//
// Throughput: one sample per cycle while the output is not stalled. The
// stages are the bit-per-stage norm square root (SAMPLE_WIDTH+9 stages),
// the 16-stage sine divider, the 16-stage cosine square root and one stage
// per CORDIC iteration.
//
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stalled receiver freezes every stage and
// drops tready; nothing is lost or repeated. Reset clears all valid bits
// and loads the tilt limit with its default (about sin 40 degrees).
module tilt_compensated_compass_sector_top #(
    parameter int SAMPLE_WIDTH = tccs_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = tccs_pkg::CORDIC_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // acc_x, acc_y, acc_z, mag_x, mag_y, mag_z from bit 0 up, zero padded
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // heading[14:0], sector[17:15], level[18], zero padded
    output logic [23:0]                         o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tccs_pkg::LIMIT_W-1:0]        i_cfg_data
);
    import tccs_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int KS  = (CORDIC_STEPS > ATAN_STEPS) ? ATAN_STEPS : CORDIC_STEPS;
    localparam int N1  = W + 9;
    localparam int TW  = W + 34;
    localparam int LAT = N1 + 43 + KS;

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    logic [LIMIT_W-1:0] r_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // input register
    logic signed [W-1:0] r_ax, r_ay, r_az, r_mx, r_my, r_mz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= $signed(i_s_axis_tdata[0*W +: W]);
            r_ay <= $signed(i_s_axis_tdata[1*W +: W]);
            r_az <= $signed(i_s_axis_tdata[2*W +: W]);
            r_mx <= $signed(i_s_axis_tdata[3*W +: W]);
            r_my <= $signed(i_s_axis_tdata[4*W +: W]);
            r_mz <= $signed(i_s_axis_tdata[5*W +: W]);
        end
    end

    // squares, then norm squared
    logic [2*W-1:0]   r_sqx, r_sqy, r_sqz;
    logic [2*W+1:0]   r_n2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= (2*W)'(r_ax * r_ax);
            r_sqy <= (2*W)'(r_ay * r_ay);
            r_sqz <= (2*W)'(r_az * r_az);
            r_n2  <= (2*W+2)'(r_sqx) + (2*W+2)'(r_sqy) + (2*W+2)'(r_sqz);
        end
    end

    logic [N1-1:0] norm8;
    tccs_isqrt #(.N(N1)) u_norm (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_n    ({r_n2, 16'd0}),
        .o_root (norm8)
    );

    logic [W-1:0] mag_r, mag_p, mag_r_d, mag_p_d;
    logic         neg_r, neg_p, neg_r_d, neg_p_d, nz_d;
    assign mag_r = r_ay[W-1] ? W'(-r_ay) : W'(r_ay);
    assign mag_p = r_ax[W-1] ? W'(-r_ax) : W'(r_ax);
    assign neg_r = !r_ay[W-1] && (r_ay != '0);
    assign neg_p = r_ax[W-1];

    tccs_delay #(.WIDTH(2*W), .DEPTH(N1 + 2)) u_dly_mag (
        .i_clk (i_clk), .i_en (en), .i_d ({mag_r, mag_p}), .o_q ({mag_r_d, mag_p_d})
    );
    tccs_delay #(.WIDTH(2), .DEPTH(N1 + 18)) u_dly_sgn (
        .i_clk (i_clk), .i_en (en), .i_d ({neg_r, neg_p}), .o_q ({neg_r_d, neg_p_d})
    );
    // span the norm root and the divider
    tccs_delay #(.WIDTH(1), .DEPTH(N1 + Q_BITS)) u_dly_nz (
        .i_clk (i_clk), .i_en (en), .i_d (r_n2 != '0), .o_q (nz_d)
    );

    logic [Q_BITS-1:0] q_r, q_p;
    tccs_div #(.NW(W), .DW(N1)) u_div_r (
        .i_clk (i_clk), .i_en (en), .i_num (mag_r_d), .i_den (norm8), .o_quo (q_r)
    );
    tccs_div #(.NW(W), .DW(N1)) u_div_p (
        .i_clk (i_clk), .i_en (en), .i_num (mag_p_d), .i_den (norm8), .o_quo (q_p)
    );

    // apply signs; zero acceleration forces level sines
    logic signed [16:0] r_sr, r_sp;
    logic               r_lvl;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (nz_d) begin
                r_sr <= neg_r_d ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
                r_sp <= neg_p_d ? -$signed({1'b0, q_p}) : $signed({1'b0, q_p});
            end else begin
                r_sr <= '0;
                r_sp <= '0;
            end
            r_lvl <= nz_d && ({1'b0, q_r} <= (Q_BITS+1)'(r_limit))
                          && ({1'b0, q_p} <= (Q_BITS+1)'(r_limit));
        end
    end

    logic [30:0]        r_ssr, r_ssp;
    logic signed [31:0] r_srsp;
    logic signed [16:0] r_sr2, r_sp2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ssr  <= 31'(r_sr * r_sr);
            r_ssp  <= 31'(r_sp * r_sp);
            r_srsp <= 32'(r_sr * r_sp);
            r_sr2  <= r_sr;
            r_sp2  <= r_sp;
        end
    end

    logic [15:0] cos_r, cos_p;
    tccs_isqrt #(.N(16)) u_cos_r (
        .i_clk (i_clk), .i_en (en), .i_n (32'h4000_0000 - 32'(r_ssr)), .o_root (cos_r)
    );
    tccs_isqrt #(.N(16)) u_cos_p (
        .i_clk (i_clk), .i_en (en), .i_n (32'h4000_0000 - 32'(r_ssp)), .o_root (cos_p)
    );

    logic [65:0] trig_d;
    tccs_delay #(.WIDTH(66), .DEPTH(16)) u_dly_trig (
        .i_clk (i_clk), .i_en (en), .i_d ({r_sr2, r_sp2, r_srsp}), .o_q (trig_d)
    );
    logic signed [16:0] sr_d, sp_d;
    logic signed [31:0] srsp_d;
    assign sr_d   = $signed(trig_d[65:49]);
    assign sp_d   = $signed(trig_d[48:32]);
    assign srsp_d = $signed(trig_d[31:0]);

    logic [3*W-1:0] mag_vec_d;
    tccs_delay #(.WIDTH(3*W), .DEPTH(N1 + 36)) u_dly_m (
        .i_clk (i_clk), .i_en (en), .i_d ({r_mx, r_my, r_mz}), .o_q (mag_vec_d)
    );
    logic signed [W-1:0] mx_d, my_d, mz_d;
    assign mx_d = $signed(mag_vec_d[2*W +: W]);
    assign my_d = $signed(mag_vec_d[1*W +: W]);
    assign mz_d = $signed(mag_vec_d[0 +: W]);

    logic signed [16:0] cr, cp;
    assign cr = $signed({1'b0, cos_r});
    assign cp = $signed({1'b0, cos_p});

    // tilt projection products
    logic signed [W+16:0] r_mxcp, r_mzsp, r_mycr, r_mycr2;
    logic signed [31:0]   r_srcp;
    logic signed [W+31:0] r_mxsrsp, r_mxsrsp2, r_mzsrcp;
    logic signed [W-1:0]  r_mz1;
    logic signed [W+17:0] r_txa;
    logic signed [TW-1:0] r_tx, r_ty;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mxcp    <= mx_d * cp;
            r_mzsp    <= mz_d * sp_d;
            r_mycr    <= my_d * cr;
            r_srcp    <= 32'(sr_d * cp);
            r_mxsrsp  <= mx_d * srsp_d;
            r_mz1     <= mz_d;

            r_mzsrcp  <= r_mz1 * r_srcp;
            r_txa     <= (W+18)'(r_mxcp) + (W+18)'(r_mzsp);
            r_mycr2   <= r_mycr;
            r_mxsrsp2 <= r_mxsrsp;

            r_tx <= TW'(r_txa) <<< 15;
            r_ty <= TW'(r_mxsrsp2) + (TW'(r_mycr2) <<< 15) - TW'(r_mzsrcp);
        end
    end

    t_angle ang;
    logic   hzero;
    tccs_cordic #(.TW(TW), .STEPS(KS)) u_cordic (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_tx),
        .i_y    (r_ty),
        .o_ang  (ang),
        .o_zero (hzero)
    );

    logic lvl_d;
    tccs_delay #(.WIDTH(1), .DEPTH(21 + KS)) u_dly_lvl (
        .i_clk (i_clk), .i_en (en), .i_d (r_lvl), .o_q (lvl_d)
    );

    // scale binary angle to 1/64 degree
    logic [46:0]       hprod;
    logic [HEAD_W-1:0] r_head;
    logic              r_lvl_h;
    assign hprod = 47'(ang) * 47'(HEAD_FULL);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head  <= hzero ? '0 : hprod[46:32];
            r_lvl_h <= lvl_d;
        end
    end

    logic [SECT_W-1:0] sect;
    always_comb begin
        sect = '0;
        if (r_head >= HEAD_W'(DEG25) && r_head < HEAD_W'(DEG340)) begin
            sect = SECT_W'(1);
            for (int k = 1; k < 7; k++) begin
                if (r_head >= HEAD_W'(DEG25 + k * DEG45)) begin
                    sect = sect + SECT_W'(1);
                end
            end
        end
    end

    logic [HEAD_W-1:0] r_o_head;
    logic [SECT_W-1:0] r_o_sect;
    logic              r_o_lvl;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_head <= r_head;
            r_o_sect <= sect;
            r_o_lvl  <= r_lvl_h;
        end
    end

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = {5'd0, r_o_lvl, r_o_sect, r_o_head};

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:0] < HEAD_W'(HEAD_FULL)))
        else $error("heading out of range");

    a_sector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[17:15] == '0) ==
            ((o_m_axis_tdata[14:0] < HEAD_W'(DEG25)) ||
             (o_m_axis_tdata[14:0] >= HEAD_W'(DEG340)))))
        else $error("sector does not match heading");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");
endmodule
